/* src/lfucct_pkg.sv */
// ----------------------------------------------------------------------------
// lfucct_pkg
// Shared types and constants of the cluster cache tag controller: slot
// count, field widths, status codes and the request and result words.
// ----------------------------------------------------------------------------
package lfucct_pkg;

    localparam int MAX_SLOTS    = 64;
    localparam int SLOT_W       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W        = $clog2(MAX_SLOTS + 1);
    localparam int CAP_W        = 7;
    localparam int TAG_W        = 32;
    localparam int USE_W        = 32;
    localparam int STATUS_W     = 3;
    localparam int SLOT_FIELD_W = 6;

    localparam logic [STATUS_W-1:0] ST_DISABLED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HIT       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_READ_MISS = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FILL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EVICT     = 3'd4;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic             func;
        logic [TAG_W-1:0] cluster_number;
    } lfucct_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [TAG_W-1:0]        evicted_cluster;
    } lfucct_out_t;

endpackage

/* src/lfu_cluster_cache_tags.sv */
// ----------------------------------------------------------------------------
// lfu_cluster_cache_tags
// Tag store and least-frequently-used replacement of a fully associative
// cluster cache; data lives outside, addressed by the reported slot.
// ----------------------------------------------------------------------------
// Usage:
//   Request words (func, cluster_number) enter on in_valid/in_ready; one
//   result word (status, slot, evicted_cluster) leaves on out_valid/out_ready
//   per request. cfg_we writes capacity_blocks; the user must do so only
//   while the block is idle, which the block itself does not enforce.
//   Each request walks the filled slots one per cycle through a single
//   tag/use-count memory read port and one shared compare unit, which finds
//   a hit and the minimum-use victim in the same pass. The walk covers the
//   filled slots, at most MAX_SLOTS of them; a hit ends the walk early.
//   in_ready is high only between requests. The result sits in an output
//   register, so a new request is taken while the last word still waits;
//   if the receiver stalls long enough, the next request holds in its
//   update step until the output register frees up.
//   Reset clears the fill count and the capacity (cache disabled); the tag
//   and use-count memories are not cleared, since only filled slots are read.
// ----------------------------------------------------------------------------
module lfu_cluster_cache_tags
    import lfucct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  lfucct_in_t  in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output lfucct_out_t out_data,
    input  logic        cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    // Tag and use-count memories, one entry per slot.
    logic [TAG_W-1:0] tag_mem [MAX_SLOTS];
    logic [USE_W-1:0] use_mem [MAX_SLOTS];

    state_t            state_reg,       state_next;
    logic              func_reg,        func_next;
    logic [TAG_W-1:0]  tag_reg,         tag_next;
    logic              cap_zero_reg,    cap_zero_next;
    logic [CNT_W-1:0]  cap_eff_reg,     cap_eff_next;
    logic [CNT_W-1:0]  scan_len_reg,    scan_len_next;
    logic [CNT_W-1:0]  issue_cnt_reg,   issue_cnt_next;
    logic              rd_v_reg,        rd_v_next;
    logic [SLOT_W-1:0] rd_idx_reg,      rd_idx_next;
    logic              hit_reg,         hit_next;
    logic [SLOT_W-1:0] hit_idx_reg,     hit_idx_next;
    logic [USE_W-1:0]  hit_uses_reg,    hit_uses_next;
    logic              have_vic_reg,    have_vic_next;
    logic [SLOT_W-1:0] vic_idx_reg,     vic_idx_next;
    logic [USE_W-1:0]  vic_uses_reg,    vic_uses_next;
    logic [TAG_W-1:0]  vic_tag_reg,     vic_tag_next;
    logic [CNT_W-1:0]  filled_reg,      filled_next;
    logic [CAP_W-1:0]  capacity_reg,    capacity_next;
    logic              out_valid_reg,   out_valid_next;
    lfucct_out_t       out_reg,         out_next;

    // Registered memory read data.
    logic [TAG_W-1:0]  rd_tag_reg;
    logic [USE_W-1:0]  rd_use_reg;

    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              tag_we;
    logic              use_we;
    logic [SLOT_W-1:0] wr_addr;
    logic [USE_W-1:0]  wr_use;
    logic              hit_now;
    logic              load_out;
    lfucct_out_t       result;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign rd_addr   = issue_cnt_reg[SLOT_W-1:0];
    assign hit_now   = (state_reg == S_SCAN) && rd_v_reg && (rd_tag_reg == tag_reg);
    assign rd_en     = (state_reg == S_SCAN) && (issue_cnt_reg < scan_len_reg) && !hit_now;
    assign load_out  = (state_reg == S_DECIDE) && (!out_valid_reg || out_ready);

    // Result and memory update of the decide step.
    always_comb
    begin
        result  = '0;
        tag_we  = 1'b0;
        use_we  = 1'b0;
        wr_addr = hit_idx_reg;
        wr_use  = '0;
        if (cap_zero_reg)
        begin
            result.status = ST_DISABLED;
        end
        else if (hit_reg)
        begin
            result.status = ST_HIT;
            result.slot   = SLOT_FIELD_W'(hit_idx_reg);
            use_we        = load_out;
            wr_use        = (hit_uses_reg == {USE_W{1'b1}}) ? hit_uses_reg
                                                             : hit_uses_reg + 1'b1;
        end
        else if (func_reg == FUNC_READ)
        begin
            result.status = ST_READ_MISS;
        end
        else if (scan_len_reg < cap_eff_reg)
        begin
            result.status = ST_FILL;
            result.slot   = SLOT_FIELD_W'(scan_len_reg);
            wr_addr       = scan_len_reg[SLOT_W-1:0];
            tag_we        = load_out;
            use_we        = load_out;
        end
        else
        begin
            result.status          = ST_EVICT;
            result.slot            = SLOT_FIELD_W'(vic_idx_reg);
            result.evicted_cluster = vic_tag_reg;
            wr_addr                = vic_idx_reg;
            tag_we                 = load_out;
            use_we                 = load_out;
        end
    end

    // Sequencer: accept, walk the filled slots, decide and write back.
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        tag_next       = tag_reg;
        cap_zero_next  = cap_zero_reg;
        cap_eff_next   = cap_eff_reg;
        scan_len_next  = scan_len_reg;
        issue_cnt_next = issue_cnt_reg;
        rd_v_next      = rd_en;
        rd_idx_next    = rd_addr;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_uses_next  = hit_uses_reg;
        have_vic_next  = have_vic_reg;
        vic_idx_next   = vic_idx_reg;
        vic_uses_next  = vic_uses_reg;
        vic_tag_next   = vic_tag_reg;
        filled_next    = filled_reg;
        capacity_next  = cfg_we ? cfg_wdata : capacity_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next      = in_data.func;
                    tag_next       = in_data.cluster_number;
                    cap_zero_next  = (capacity_reg == '0);
                    cap_eff_next   = (32'(capacity_reg) > 32'(MAX_SLOTS))
                                     ? CNT_W'(MAX_SLOTS) : CNT_W'(capacity_reg);
                    // A disabled cache skips the walk.
                    scan_len_next  = (capacity_reg == '0) ? '0 : filled_reg;
                    issue_cnt_next = '0;
                    hit_next       = 1'b0;
                    have_vic_next  = 1'b0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (hit_now)
                begin
                    hit_next      = 1'b1;
                    hit_idx_next  = rd_idx_reg;
                    hit_uses_next = rd_use_reg;
                    state_next    = S_DECIDE;
                end
                else
                begin
                    if (rd_v_reg && (!have_vic_reg || rd_use_reg < vic_uses_reg))
                    begin
                        have_vic_next = 1'b1;
                        vic_idx_next  = rd_idx_reg;
                        vic_uses_next = rd_use_reg;
                        vic_tag_next  = rd_tag_reg;
                    end
                    if (!rd_en && !rd_v_reg)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_next       = result;
                    if (!cap_zero_reg && !hit_reg && func_reg == FUNC_WRITE &&
                        scan_len_reg < cap_eff_reg)
                    begin
                        filled_next = filled_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_v_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            have_vic_reg  <= 1'b0;
            cap_zero_reg  <= 1'b1;
            issue_cnt_reg <= '0;
            scan_len_reg  <= '0;
            filled_reg    <= '0;
            capacity_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_v_reg      <= rd_v_next;
            hit_reg       <= hit_next;
            have_vic_reg  <= have_vic_next;
            cap_zero_reg  <= cap_zero_next;
            issue_cnt_reg <= issue_cnt_next;
            scan_len_reg  <= scan_len_next;
            filled_reg    <= filled_next;
            capacity_reg  <= capacity_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        tag_reg      <= tag_next;
        cap_eff_reg  <= cap_eff_next;
        rd_idx_reg   <= rd_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_uses_reg <= hit_uses_next;
        vic_idx_reg  <= vic_idx_next;
        vic_uses_reg <= vic_uses_next;
        vic_tag_reg  <= vic_tag_next;
    end

    // Memories: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[wr_addr] <= tag_reg;
        end
        rd_tag_reg <= tag_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (use_we)
        begin
            use_mem[wr_addr] <= wr_use;
        end
        rd_use_reg <= use_mem[rd_addr];
    end

    // The fill count never runs past the slot count.
    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= CNT_W'(MAX_SLOTS))
        else $error("fill count beyond slot count");

    // The walk never reads past the filled slots.
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_cnt_reg <= scan_len_reg))
        else $error("slot walk past fill count");

    // A free-slot fill bumps the fill count by exactly one.
    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && result.status == ST_FILL) |=>
            (filled_reg == $past(filled_reg) + 1'b1))
        else $error("fill did not advance fill count");

    // An eviction only happens with the cache full.
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && result.status == ST_EVICT) |->
            (filled_reg >= cap_eff_reg && !cap_zero_reg))
        else $error("eviction with free slots left");

endmodule
